@@ src/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and codes for the page frame allocator: command and status
// codes, the request, result and internal work item structs.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  // command codes on the request port
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFRAMES = 2'd1;
  localparam logic [1:0] ST_HELD     = 2'd2;

  // frames examined per cycle by the lowest-free search
  localparam int SCAN_W = 16;

  // queue depths
  localparam int CQ_DEPTH = 2;
  localparam int RQ_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_READ
  } op_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] proc_id;
    logic [3:0] page_count;
    logic [2:0] page_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] frame;
    logic       frame_valid;
    logic [4:0] free_left;
    logic       last;
  } rsp_t;

  // classified command as handed from the front end to the engine
  typedef struct packed {
    op_t        op;
    logic [3:0] pid;
    logic [3:0] count;
    logic       count_over;
    logic [2:0] index;
    logic       index_ok;
  } work_t;

endpackage

`default_nettype wire

@@ src/pfa_fifo.sv @@
// ----------------------------------------------------------------------------
// pfa_fifo
// Small synchronous queue with full/empty flags, used between the front end
// and the engine and for the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/pfa_front.sv @@
// ----------------------------------------------------------------------------
// pfa_front
// Request front end: decodes the command, folds the process id into range,
// pre-checks page count and index, and queues the work item for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_front #(
  parameter int MAX_PROCS      = 16,
  parameter int PAGES_PER_PROC = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  pfa_pkg::req_t  req,
  input  logic           wk_pop,
  output logic           wk_empty,
  output pfa_pkg::work_t wk
);

  pfa_pkg::work_t wk_in;
  logic           cmd_known;
  logic           q_full;

  // process id modulo MAX_PROCS, as a sixteen-entry constant table
  function automatic logic [3:0] wrap_pid(input logic [3:0] p);
    logic [3:0] r;
    r = '0;
    for (int v = 0; v < 16; v++) begin
      if (p == 4'(v)) begin
        r = 4'(v % MAX_PROCS);
      end
    end
    return r;
  endfunction

  always_comb begin
    wk_in            = '0;
    cmd_known        = 1'b1;
    wk_in.pid        = wrap_pid(req.proc_id);
    wk_in.count      = req.page_count;
    wk_in.count_over = int'(req.page_count) > PAGES_PER_PROC;
    wk_in.index      = req.page_index;
    wk_in.index_ok   = int'(req.page_index) < PAGES_PER_PROC;
    unique case (req.cmd)
      pfa_pkg::CMD_ALLOC: wk_in.op = pfa_pkg::OP_ALLOC;
      pfa_pkg::CMD_FREE:  wk_in.op = pfa_pkg::OP_FREE;
      pfa_pkg::CMD_READ:  wk_in.op = pfa_pkg::OP_READ;
      default: begin
        // unused code: taken and dropped
        wk_in.op  = pfa_pkg::OP_READ;
        cmd_known = 1'b0;
      end
    endcase
  end

  assign full = q_full;

  pfa_fifo #(
    .W     ($bits(pfa_pkg::work_t)),
    .DEPTH (pfa_pkg::CQ_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && cmd_known),
    .full  (q_full),
    .wdata (wk_in),
    .pop   (wk_pop),
    .empty (wk_empty),
    .rdata (wk)
  );

endmodule

`default_nettype wire

@@ src/pfa_back.sv @@
// ----------------------------------------------------------------------------
// pfa_back
// Allocation engine: holds the free-frame bitmap, free count, per-process page
// counts and the page table memory, and carries out one command at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_back #(
  parameter int NUM_FRAMES     = 16,
  parameter int MAX_PROCS      = 16,
  parameter int PAGES_PER_PROC = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wk_empty,
  input  pfa_pkg::work_t wk,
  output logic           wk_pop,
  input  logic           res_full,
  output logic           res_push,
  output pfa_pkg::rsp_t  res
);

  localparam int FIDX_W  = $clog2(NUM_FRAMES);
  localparam int FT_W    = $clog2(NUM_FRAMES + 1);
  localparam int PIDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W   = $clog2(PAGES_PER_PROC + 1);
  localparam int PG_W    = (PAGES_PER_PROC > 1) ? $clog2(PAGES_PER_PROC) : 1;
  localparam int ENTRIES = MAX_PROCS * PAGES_PER_PROC;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NCH     = (NUM_FRAMES + pfa_pkg::SCAN_W - 1) / pfa_pkg::SCAN_W;
  localparam int CH_W    = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int ENC_W   = $clog2(pfa_pkg::SCAN_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ALLOC,
    S_FREE_RD,
    S_FREE_REL,
    S_FREE_DONE
  } state_t;

  state_t         state;
  pfa_pkg::work_t cur;
  logic [CNT_W-1:0] cur_held;
  logic [CNT_W-1:0] page;
  logic [CH_W-1:0]  chunk;

  logic [NUM_FRAMES-1:0] free_map;
  logic [FT_W-1:0]       free_total;

  // page counts per process; an entry reads as zero until held_vld is set
  logic [CNT_W-1:0]     held_mem [MAX_PROCS];
  logic [MAX_PROCS-1:0] held_vld;
  logic [CNT_W-1:0]     held_rd;
  logic                 held_rd_vld;

  // page table: entry (pid, i) is mapped exactly when i < page count of pid
  logic [FIDX_W-1:0] frame_mem [ENTRIES];
  logic [FIDX_W-1:0] frame_rd;
  logic [AW-1:0]     fm_raddr;
  logic              fm_ren;
  logic [AW-1:0]     fm_waddr;

  logic [PIDX_W-1:0] wk_pidx;
  logic [PIDX_W-1:0] cur_pidx;
  logic [CNT_W-1:0]  held_now;
  logic              alloc_go;
  logic              alloc_last;
  logic              take;

  logic [NCH*pfa_pkg::SCAN_W-1:0] map_pad;
  logic [pfa_pkg::SCAN_W-1:0]     chunk_bits;
  logic                           chunk_any;
  logic [ENC_W-1:0]               enc;
  logic [FIDX_W-1:0]              pick_frame;

  function automatic logic [AW-1:0] entry_addr(input logic [3:0] pid,
                                               input logic [PG_W-1:0] pg);
    return AW'(int'(pid) * PAGES_PER_PROC + int'(pg));
  endfunction

  assign wk_pidx  = PIDX_W'(wk.pid);
  assign cur_pidx = PIDX_W'(cur.pid);
  assign held_now = held_rd_vld ? held_rd : '0;

  // lowest free frame within the current group of frames
  always_comb begin
    map_pad                 = '0;
    map_pad[NUM_FRAMES-1:0] = free_map;
    chunk_bits = map_pad[int'(chunk) * pfa_pkg::SCAN_W +: pfa_pkg::SCAN_W];
    chunk_any  = |chunk_bits;
    enc        = '0;
    for (int b = pfa_pkg::SCAN_W - 1; b >= 0; b--) begin
      if (chunk_bits[b]) begin
        enc = ENC_W'(b);
      end
    end
    pick_frame = FIDX_W'(int'(chunk) * pfa_pkg::SCAN_W + int'(enc));
  end

  assign alloc_go = (held_now == '0) && !cur.count_over &&
                    (int'(cur.count) <= int'(free_total)) && (cur.count != '0);
  assign alloc_last = (int'(page) + 1 == int'(cur.count));
  assign take       = (state == S_ALLOC) && chunk_any && !res_full;

  // page table address and read enable
  always_comb begin
    fm_ren   = 1'b0;
    fm_raddr = '0;
    if (state == S_IDLE) begin
      fm_ren   = 1'b1;
      fm_raddr = entry_addr(wk.pid, wk.index_ok ? PG_W'(wk.index) : '0);
    end else if (state == S_FREE_RD) begin
      fm_ren   = 1'b1;
      fm_raddr = entry_addr(cur.pid, PG_W'(page));
    end
    fm_waddr = entry_addr(cur.pid, PG_W'(page));
  end

  // result and queue handshakes
  always_comb begin
    wk_pop          = 1'b0;
    res_push        = 1'b0;
    res             = '0;
    res.status      = pfa_pkg::ST_OK;
    res.free_left   = 5'(free_total);
    res.last        = 1'b1;
    unique case (state)
      S_IDLE: wk_pop = !wk_empty;
      S_EXEC: begin
        if (!res_full) begin
          unique case (cur.op)
            pfa_pkg::OP_READ: begin
              res_push = 1'b1;
              if (cur.index_ok && (int'(cur.index) < int'(held_now))) begin
                res.frame       = 4'(frame_rd);
                res.frame_valid = 1'b1;
              end
            end
            pfa_pkg::OP_ALLOC: begin
              res_push = !alloc_go;
              if (held_now != '0) begin
                res.status = pfa_pkg::ST_HELD;
              end else if (cur.count_over || (int'(cur.count) > int'(free_total))) begin
                res.status = pfa_pkg::ST_NOFRAMES;
              end
            end
            pfa_pkg::OP_FREE: res_push = (held_now == '0);
            default: res_push = 1'b0;
          endcase
        end
      end
      S_ALLOC: begin
        res_push        = take;
        res.frame       = 4'(pick_frame);
        res.frame_valid = 1'b1;
        res.free_left   = 5'(free_total - 1'b1);
        res.last        = alloc_last;
      end
      S_FREE_DONE: res_push = !res_full;
      default: res_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fm_ren) begin
      frame_rd <= frame_mem[fm_raddr];
    end
    if (take) begin
      frame_mem[fm_waddr] <= pick_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      held_rd     <= held_mem[wk_pidx];
      held_rd_vld <= held_vld[wk_pidx];
    end
    if (take && alloc_last) begin
      held_mem[cur_pidx] <= CNT_W'(cur.count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_map   <= '1;
      free_total <= FT_W'(NUM_FRAMES);
      held_vld   <= '0;
      page       <= '0;
      chunk      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!wk_empty) begin
            cur   <= wk;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!res_full) begin
            cur_held <= held_now;
            page     <= '0;
            chunk    <= '0;
            if (cur.op == pfa_pkg::OP_ALLOC && alloc_go) begin
              state <= S_ALLOC;
            end else if (cur.op == pfa_pkg::OP_FREE && held_now != '0) begin
              state <= S_FREE_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_ALLOC: begin
          if (!chunk_any) begin
            if (int'(chunk) < NCH - 1) begin
              chunk <= chunk + 1'b1;
            end
          end else if (!res_full) begin
            free_map[pick_frame] <= 1'b0;
            free_total           <= free_total - 1'b1;
            page                 <= page + 1'b1;
            if (alloc_last) begin
              held_vld[cur_pidx] <= 1'b1;
              state              <= S_IDLE;
            end
          end
        end
        S_FREE_RD: state <= S_FREE_REL;
        S_FREE_REL: begin
          free_map[frame_rd] <= 1'b1;
          free_total         <= free_total + 1'b1;
          page               <= page + 1'b1;
          if (int'(page) + 1 == int'(cur_held)) begin
            state <= S_FREE_DONE;
          end else begin
            state <= S_FREE_RD;
          end
        end
        S_FREE_DONE: begin
          if (!res_full) begin
            held_vld[cur_pidx] <= 1'b0;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    int'(free_total) <= NUM_FRAMES)
    else $error("free count above number of frames");

  a_total_matches_map: assert property (@(posedge clk) disable iff (rst)
    $countones(free_map) == int'(free_total))
    else $error("free count out of step with bitmap");

  a_take_is_free: assert property (@(posedge clk) disable iff (rst)
    take |-> free_map[pick_frame])
    else $error("allocated a frame that is not free");

  a_release_is_used: assert property (@(posedge clk) disable iff (rst)
    (state == S_FREE_REL) |-> !free_map[frame_rd])
    else $error("released a frame that was already free");

  a_result_space: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

endmodule

`default_nettype wire

@@ src/page_frame_allocator_top.sv @@
// ----------------------------------------------------------------------------
// page_frame_allocator_top
// First-fit page frame allocator. Requests are pushed into a two-entry
// command queue and executed one at a time by the engine; results leave
// through a four-entry queue, so either side may stall. Allocate of N pages
// gives one result per page, each page getting the lowest free frame.
// Read, refused or zero-page allocate, and free of an empty process give a
// single result from the execute state; allocate of N pages takes one frame
// per page, the frame search stepping over each fully used group of 16
// frames; free of a process holding H pages reads and releases its frames
// one after another, as the page table memory has a single read port.
// Command code 3 is accepted and dropped. No start-up pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_allocator_top #(
  parameter int NUM_FRAMES     = 16,
  parameter int MAX_PROCS      = 16,
  parameter int PAGES_PER_PROC = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  pfa_pkg::req_t req,
  output logic          empty,
  input  logic          pop,
  output pfa_pkg::rsp_t rsp
);

  pfa_pkg::work_t wk;
  logic           wk_empty;
  logic           wk_pop;
  pfa_pkg::rsp_t  res;
  logic           res_push;
  logic           res_full;

  pfa_front #(
    .MAX_PROCS      (MAX_PROCS),
    .PAGES_PER_PROC (PAGES_PER_PROC)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .req      (req),
    .wk_pop   (wk_pop),
    .wk_empty (wk_empty),
    .wk       (wk)
  );

  pfa_back #(
    .NUM_FRAMES     (NUM_FRAMES),
    .MAX_PROCS      (MAX_PROCS),
    .PAGES_PER_PROC (PAGES_PER_PROC)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .wk_empty (wk_empty),
    .wk       (wk),
    .wk_pop   (wk_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  pfa_fifo #(
    .W     ($bits(pfa_pkg::rsp_t)),
    .DEPTH (pfa_pkg::RQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .wdata (res),
    .pop   (pop),
    .empty (empty),
    .rdata (rsp)
  );

endmodule

`default_nettype wire
